[rtl/cdo_pkg.sv]
// ----------------------------------------------------------------------------
// cdo_pkg
// Shared types, constants and calendar tables for the date offset block.
// ----------------------------------------------------------------------------
`default_nettype none

package cdo_pkg;

    // Serial counts cover up to 9999 years of at most 366 days each.
    localparam int SER_W = 22;
    // Signed sum of a serial count and a 20 bit offset.
    localparam int SUM_W = 24;
    // Year counter width, enough for the largest last year.
    localparam int YR_W  = 14;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    typedef struct packed {
        logic [4:0]         day_in;
        logic [3:0]         month_in;
        logic [11:0]        year_in;
        logic signed [19:0] offset_days;
    } t_in_item;

    typedef struct packed {
        logic        input_valid;
        logic [19:0] serial_days;
        logic [4:0]  result_day;
        logic [3:0]  result_month;
        logic [11:0] result_year;
        logic        out_of_range;
    } t_out_item;

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        logic             valid;
        logic [SER_W-1:0] serial;
        logic             oor;
        logic [SER_W-1:0] sum;
    } t_job;

    typedef enum logic [1:0] {
        F_IDLE,
        F_WALK,
        F_CHECK,
        F_PUSH
    } t_front_state;

    typedef enum logic [1:0] {
        B_IDLE,
        B_YEAR,
        B_MONTH,
        B_OUT
    } t_back_state;

    function automatic logic [8:0] year_len(input logic leap);
        return leap ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        case (month)
            4'd2:                      len = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
            default:                   len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before_month(input logic [3:0] month,
                                                     input logic       leap);
        logic [8:0] days;
        case (month)
            4'd1:    days = 9'd0;
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        if (leap && (month > MONTH_FEB)) begin
            days = days + 9'd1;
        end
        return days;
    endfunction

endpackage

`default_nettype wire

[rtl/cdo_year_ctr.sv]
// ----------------------------------------------------------------------------
// cdo_year_ctr
// Year counter from the epoch year with running remainders for the leap rule.
// ----------------------------------------------------------------------------
`default_nettype none

module cdo_year_ctr #(
    parameter int EPOCH_YEAR = 1970
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_load,
    input  wire logic                    i_step,
    output logic [cdo_pkg::YR_W-1:0]     o_year,
    output logic                         o_leap
);
    import cdo_pkg::*;

    localparam logic [1:0] M4_INIT   = 2'(EPOCH_YEAR % 4);
    localparam logic [6:0] M100_INIT = 7'(EPOCH_YEAR % 100);
    localparam logic [8:0] M400_INIT = 9'(EPOCH_YEAR % 400);

    logic [YR_W-1:0] r_year;
    logic [1:0]      r_m4;
    logic [6:0]      r_m100;
    logic [8:0]      r_m400;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_year <= YR_W'(EPOCH_YEAR);
            r_m4   <= M4_INIT;
            r_m100 <= M100_INIT;
            r_m400 <= M400_INIT;
        end else if (i_step) begin
            r_year <= r_year + YR_W'(1);
            r_m4   <= r_m4 + 2'd1;
            r_m100 <= (r_m100 == 7'd99)  ? 7'd0 : r_m100 + 7'd1;
            r_m400 <= (r_m400 == 9'd399) ? 9'd0 : r_m400 + 9'd1;
        end
    end

    assign o_year = r_year;
    assign o_leap = ((r_m4 == 2'd0) && (r_m100 != 7'd0)) || (r_m400 == 9'd0);

endmodule

`default_nettype wire

[rtl/cdo_front.sv]
// ----------------------------------------------------------------------------
// cdo_front
// Takes an item, checks the date, counts its serial day and adds the offset.
// ----------------------------------------------------------------------------
`default_nettype none

module cdo_front #(
    parameter int EPOCH_YEAR = 1970,
    parameter int LAST_YEAR  = 4095
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire cdo_pkg::t_in_item i_item,
    output logic                   o_busy,
    input  wire logic              i_q_full,
    output logic                   o_push,
    output cdo_pkg::t_job          o_job
);
    import cdo_pkg::*;

    localparam int P0 = EPOCH_YEAR - 1;
    localparam int P1 = LAST_YEAR;
    localparam int MAX_SERIAL = (365 * P1 + P1 / 4 - P1 / 100 + P1 / 400)
                              - (365 * P0 + P0 / 4 - P0 / 100 + P0 / 400);

    t_front_state r_state, n_state;

    logic [4:0]         r_day;
    logic [3:0]         r_month;
    logic [11:0]        r_year;
    logic signed [19:0] r_off;
    logic               r_range_ok;
    logic [SER_W-1:0]   r_acc;
    logic [SER_W-1:0]   r_serial;
    logic               r_valid;

    logic            accept;
    logic            ctr_step;
    logic            at_year;
    logic            range_ok;
    logic            day_ok;
    logic [YR_W-1:0] ctr_year;
    logic            ctr_leap;
    logic [SUM_W-1:0] sum;
    logic            oor;

    cdo_year_ctr #(
        .EPOCH_YEAR (EPOCH_YEAR)
    ) u_year_ctr (
        .i_clk  (i_clk),
        .i_load (accept),
        .i_step (ctr_step),
        .o_year (ctr_year),
        .o_leap (ctr_leap)
    );

    assign at_year  = (ctr_year == YR_W'(r_year));
    assign range_ok = (i_item.month_in inside {[MONTH_JAN:MONTH_DEC]})
                   && (YR_W'(i_item.year_in) >= YR_W'(EPOCH_YEAR))
                   && (YR_W'(i_item.year_in) <= YR_W'(LAST_YEAR))
                   && (i_item.day_in != 5'd0);
    assign day_ok   = r_range_ok && (r_day <= month_len(r_month, ctr_leap));

    assign sum = SUM_W'(r_serial) + SUM_W'(r_off);
    assign oor = sum[SUM_W-1] || (sum == '0) || (sum > SUM_W'(MAX_SERIAL));

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (i_start) begin
                    n_state = range_ok ? F_WALK : F_CHECK;
                end
            end
            F_WALK: begin
                if (at_year) begin
                    n_state = F_CHECK;
                end
            end
            F_CHECK: n_state = F_PUSH;
            F_PUSH: begin
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        accept   = 1'b0;
        ctr_step = 1'b0;
        o_push   = 1'b0;
        o_busy   = 1'b1;
        case (r_state)
            F_IDLE: begin
                o_busy = 1'b0;
                accept = i_start;
            end
            F_WALK:  ctr_step = !at_year;
            F_CHECK: ;
            F_PUSH:  o_push = !i_q_full;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_day      <= i_item.day_in;
            r_month    <= i_item.month_in;
            r_year     <= i_item.year_in;
            r_off      <= i_item.offset_days;
            r_range_ok <= range_ok;
            r_acc      <= '0;
        end else if (ctr_step) begin
            r_acc <= r_acc + SER_W'(year_len(ctr_leap));
        end
        if (r_state == F_CHECK) begin
            r_valid  <= day_ok;
            r_serial <= day_ok ? r_acc + SER_W'(days_before_month(r_month, ctr_leap))
                                       + SER_W'(r_day)
                               : '0;
        end
    end

    assign o_job.valid  = r_valid;
    assign o_job.serial = r_serial;
    assign o_job.oor    = oor;
    assign o_job.sum    = sum[SER_W-1:0];

endmodule

`default_nettype wire

[rtl/cdo_queue.sv]
// ----------------------------------------------------------------------------
// cdo_queue
// Two-entry queue of classified items between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module cdo_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire cdo_pkg::t_job i_job,
    input  wire logic          i_pop,
    output cdo_pkg::t_job      o_job,
    output logic               o_full,
    output logic               o_empty
);
    import cdo_pkg::*;

    t_job       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    assign o_job   = r_mem[r_rd_ptr];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

endmodule

`default_nettype wire

[rtl/cdo_back.sv]
// ----------------------------------------------------------------------------
// cdo_back
// Turns a shifted serial count back into a date by walking years then months.
// ----------------------------------------------------------------------------
`default_nettype none

module cdo_back #(
    parameter int EPOCH_YEAR = 1970
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire cdo_pkg::t_job i_job,
    input  wire logic          i_empty,
    output logic               o_pop,
    output logic               o_done,
    output cdo_pkg::t_out_item o_result
);
    import cdo_pkg::*;

    t_back_state r_state, n_state;

    logic [SER_W-1:0] r_rem;
    logic [3:0]       r_month;
    logic             r_valid;
    logic [SER_W-1:0] r_serial;
    logic             r_oor;

    logic             ctr_step;
    logic             month_step;
    logic [YR_W-1:0]  ctr_year;
    logic             ctr_leap;
    logic [8:0]       ylen;
    logic [4:0]       mlen;
    logic             more_years;
    logic             more_months;

    cdo_year_ctr #(
        .EPOCH_YEAR (EPOCH_YEAR)
    ) u_year_ctr (
        .i_clk  (i_clk),
        .i_load (o_pop),
        .i_step (ctr_step),
        .o_year (ctr_year),
        .o_leap (ctr_leap)
    );

    assign ylen        = year_len(ctr_leap);
    assign mlen        = month_len(r_month, ctr_leap);
    assign more_years  = (r_rem > SER_W'(ylen));
    assign more_months = (r_month < MONTH_DEC) && (r_rem > SER_W'(mlen));

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    n_state = i_job.oor ? B_OUT : B_YEAR;
                end
            end
            B_YEAR: begin
                if (!more_years) begin
                    n_state = B_MONTH;
                end
            end
            B_MONTH: begin
                if (!more_months) begin
                    n_state = B_OUT;
                end
            end
            B_OUT:   n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_comb begin
        o_pop      = 1'b0;
        ctr_step   = 1'b0;
        month_step = 1'b0;
        o_done     = 1'b0;
        case (r_state)
            B_IDLE:  o_pop      = !i_empty;
            B_YEAR:  ctr_step   = more_years;
            B_MONTH: month_step = more_months;
            B_OUT:   o_done     = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rem    <= i_job.sum;
            r_month  <= MONTH_JAN;
            r_valid  <= i_job.valid;
            r_serial <= i_job.serial;
            r_oor    <= i_job.oor;
        end else if (ctr_step) begin
            r_rem <= r_rem - SER_W'(ylen);
        end else if (month_step) begin
            r_rem   <= r_rem - SER_W'(mlen);
            r_month <= r_month + 4'd1;
        end
    end

    always_comb begin
        o_result.input_valid  = r_valid;
        o_result.serial_days  = r_serial[19:0];
        o_result.result_day   = r_oor ? 5'd0  : r_rem[4:0];
        o_result.result_month = r_oor ? 4'd0  : r_month;
        o_result.result_year  = r_oor ? 12'd0 : ctr_year[11:0];
        o_result.out_of_range = r_oor;
    end

endmodule

`default_nettype wire

[rtl/calendar_date_offset.sv]
// ----------------------------------------------------------------------------
// calendar_date_offset
// Gregorian date check, serial day count, signed offset and date recovery.
// ----------------------------------------------------------------------------
// An item (day, month, year, signed offset) is taken on a rising edge with
// start high and busy low. The front end walks the years from EPOCH_YEAR up
// to the given year, one year per cycle, to form the serial count, then adds
// the offset, with busy high until the item is pushed into the queue.
// The result goes through a two-entry queue to the back end, which walks the
// shifted count year by year and then month by month, or skips both walks
// when the sum is out of range. Both walks run one year per cycle through
// their own year counter.
// Each result appears on o_result for one cycle with o_done high; the
// receiver must take it then, as it cannot stall the block. The front end
// takes a new item while the back end still works on the previous ones.
// Reset (i_rst_n low at a clock edge) empties the queue and idles both ends.
// ----------------------------------------------------------------------------
`default_nettype none

module calendar_date_offset #(
    parameter int EPOCH_YEAR = 1970,
    parameter int LAST_YEAR  = 4095
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire cdo_pkg::t_in_item  i_item,
    output logic                    busy,
    output logic                    o_done,
    output cdo_pkg::t_out_item      o_result
);
    import cdo_pkg::*;

    t_job front_job;
    t_job head_job;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    cdo_front #(
        .EPOCH_YEAR (EPOCH_YEAR),
        .LAST_YEAR  (LAST_YEAR)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (i_item),
        .o_busy   (busy),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (front_job)
    );

    cdo_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    cdo_back #(
        .EPOCH_YEAR (EPOCH_YEAR)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_job    (head_job),
        .i_empty  (q_empty),
        .o_pop    (pop),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // An invalid date always reports a zero serial count.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.input_valid |-> o_result.serial_days == 20'd0)
        else $error("invalid date with non-zero serial count");

    // An in-range result is a real calendar date.
    a_result_date: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_result.out_of_range |->
            o_result.result_day != 5'd0 && o_result.result_month != 4'd0 &&
            o_result.result_month <= MONTH_DEC)
        else $error("in-range result is not a calendar date");

    // The back end returns to idle after every result.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // The queue is never pushed while full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_full)
        else $error("item pushed into a full queue");

endmodule

`default_nettype wire
